FILE: hw/rtl/tgcb_pkg.sv
//------------------------------------------------------------------------------
// tgcb_pkg
// Shared types and constants for the tilt / gyro complementary blend unit.
//------------------------------------------------------------------------------
package tgcb_pkg;

	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_RANGE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GYRO_RANGE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_W     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_OFS_X  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TILT_OFS_Y  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_X     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_Y     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_DRIFT_Z     = 3'd7;

	localparam int MAX_STEPS = 24;

	typedef struct packed {
		logic signed [15:0] accel_x;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic [15:0]        elapsed_ms;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] roll_deg;
		logic signed [31:0] pitch_deg;
		logic signed [31:0] yaw_deg;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // latch input item, start root
		logic sqrt_step;  // one root iteration (both axes)
		logic cordic_init;
		logic cordic_step;
		logic gyro_mul;   // rate*fs/250 as a shift (per axis index)
		logic gyro_mul2;  // *ms
		logic gyro_div;   // halve with rounding (/500 in all) and accumulate
		logic blend_mul;
		logic blend_fin;
		logic [1:0] axis;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic sqrt_done;
		logic cordic_done;
	} dp_stat_t;

	function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0: r = 32'sd2949120;  5'd1: r = 32'sd1740967;
			5'd2: r = 32'sd919879;   5'd3: r = 32'sd466945;
			5'd4: r = 32'sd234379;   5'd5: r = 32'sd117305;
			5'd6: r = 32'sd58666;    5'd7: r = 32'sd29335;
			5'd8: r = 32'sd14668;    5'd9: r = 32'sd7334;
			5'd10: r = 32'sd3667;    5'd11: r = 32'sd1833;
			5'd12: r = 32'sd917;     5'd13: r = 32'sd458;
			5'd14: r = 32'sd229;     5'd15: r = 32'sd115;
			5'd16: r = 32'sd57;      5'd17: r = 32'sd29;
			5'd18: r = 32'sd14;      5'd19: r = 32'sd7;
			5'd20: r = 32'sd4;       5'd21: r = 32'sd2;
			5'd22: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [10:0] gyro_fs(input logic [1:0] sel);
		logic [10:0] r;
		case (sel)
			2'd0: r = 11'd250;
			2'd1: r = 11'd500;
			2'd2: r = 11'd1000;
			default: r = 11'd2000;
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/tgcb_stream_if.sv
//------------------------------------------------------------------------------
// tgcb_stream_if
// Valid/ready channel carrying one payload beat.
//------------------------------------------------------------------------------
interface tgcb_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/tgcb_ctrl.sv
//------------------------------------------------------------------------------
// tgcb_ctrl
// Sequencer: root, CORDIC, gyro integration and blend phases per beat.
//------------------------------------------------------------------------------
module tgcb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  tgcb_pkg::dp_stat_t stat,
	output tgcb_pkg::dp_cmd_t  cmd
);
	import tgcb_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQRT = 3'd1;
	localparam logic [2:0] ST_CORD = 3'd2;
	localparam logic [2:0] ST_GYRO = 3'd3;
	localparam logic [2:0] ST_BLND = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0] state_q;
	logic [1:0] axis_q;
	logic [1:0] sub_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	always_comb begin
		cmd = '0;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_SQRT: cmd.sqrt_step = 1'b1;
			ST_CORD: begin
				cmd.cordic_init = (sub_q == 2'd0);
				cmd.cordic_step = (sub_q != 2'd0);
			end
			ST_GYRO: begin
				cmd.gyro_mul  = (sub_q == 2'd0);
				cmd.gyro_mul2 = (sub_q == 2'd1);
				cmd.gyro_div  = (sub_q == 2'd2);
			end
			ST_BLND: begin
				cmd.blend_mul = (sub_q == 2'd0);
				cmd.blend_fin = (sub_q == 2'd1);
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			sub_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SQRT;
				ST_SQRT: if (stat.sqrt_done) begin
					state_q <= ST_CORD;
					sub_q   <= '0;
				end
				ST_CORD: begin
					if (sub_q == 2'd0) sub_q <= 2'd1;
					else if (stat.cordic_done) begin
						state_q <= ST_GYRO;
						sub_q   <= '0;
						axis_q  <= '0;
					end
				end
				ST_GYRO: begin
					if (sub_q == 2'd2) begin
						sub_q <= '0;
						if (axis_q == 2'd2) begin
							axis_q  <= '0;
							state_q <= ST_BLND;
						end else axis_q <= axis_q + 2'd1;
					end else sub_q <= sub_q + 2'd1;
				end
				ST_BLND: begin
					if (sub_q == 2'd1) begin
						sub_q <= '0;
						if (axis_q == 2'd1) begin
							axis_q  <= '0;
							state_q <= ST_OUT;
						end else axis_q <= axis_q + 2'd1;
					end else sub_q <= 2'd1;
				end
				ST_OUT: if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/tgcb_dpath.sv
//------------------------------------------------------------------------------
// tgcb_dpath
// Datapath: bit-serial roots, shared-step CORDIC pair, gyro integrators,
// blend multiplier and configuration registers.
//------------------------------------------------------------------------------
module tgcb_dpath #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tgcb_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [tgcb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  tgcb_pkg::in_item_t                   in_item,
	input  tgcb_pkg::dp_cmd_t                    cmd,
	output tgcb_pkg::dp_stat_t                   stat,
	output tgcb_pkg::out_item_t                  out_item
);
	import tgcb_pkg::*;

	localparam int CNT_W = $clog2(MAX_STEPS + 1);

	logic [1:0]         gyro_sel_q;
	logic [15:0]        blend_w_q;
	logic signed [31:0] tilt_ofs_q [2];
	logic signed [31:0] drift_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_sel_q  <= 2'd3;
			blend_w_q   <= 16'd62915;
			tilt_ofs_q[0] <= '0; tilt_ofs_q[1] <= '0;
			drift_q[0] <= '0; drift_q[1] <= '0; drift_q[2] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_ACCEL_RANGE: ; // full scale cancels in the tilt angles
				REG_GYRO_RANGE:  gyro_sel_q  <= cfg_data[1:0];
				REG_BLEND_W:     blend_w_q   <= cfg_data[15:0];
				REG_TILT_OFS_X:  tilt_ofs_q[0] <= cfg_data;
				REG_TILT_OFS_Y:  tilt_ofs_q[1] <= cfg_data;
				REG_DRIFT_X:     drift_q[0] <= cfg_data;
				REG_DRIFT_Y:     drift_q[1] <= cfg_data;
				REG_DRIFT_Z:     drift_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched item
	in_item_t item_q;
	always_ff @(posedge clk) if (cmd.load) item_q <= in_item;

	// --- roots: two restoring square roots of 50-bit radicands, 25 steps
	logic [49:0] rad_q [2];
	logic [25:0] rem_q [2];
	logic [24:0] root_q [2];
	logic [4:0]  sq_cnt_q;
	logic [32:0] sumsq [2];
	logic signed [31:0] p0, p1, p2, p3;

	assign p0 = in_item.accel_x * in_item.accel_x;
	assign p1 = in_item.accel_z * in_item.accel_z;
	assign p2 = in_item.accel_y * in_item.accel_y;
	assign sumsq[0] = {1'b0, p0} + {1'b0, p1};
	assign sumsq[1] = {1'b0, p2} + {1'b0, p1};
	assign p3 = '0;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int k = 0; k < 2; k++) begin
				rad_q[k]  <= {sumsq[k] + {1'b0, p3}, 16'd0} ;
				rem_q[k]  <= '0;
				root_q[k] <= '0;
			end
			sq_cnt_q <= '0;
		end else if (cmd.sqrt_step) begin
			for (int k = 0; k < 2; k++) begin
				logic [27:0] trial;
				logic [27:0] r2;
				r2 = {rem_q[k], rad_q[k][49:48]};
				trial = r2 - {1'b0, root_q[k], 2'b01};
				if (!trial[27]) begin
					rem_q[k]  <= trial[25:0];
					root_q[k] <= {root_q[k][23:0], 1'b1};
				end else begin
					rem_q[k]  <= r2[25:0];
					root_q[k] <= {root_q[k][23:0], 1'b0};
				end
				rad_q[k] <= {rad_q[k][47:0], 2'b00};
			end
			sq_cnt_q <= sq_cnt_q + 5'd1;
		end
	end

	// --- CORDIC vectoring, both tilt axes in lockstep
	logic signed [31:0] cx_q [2], cy_q [2], cz_q [2];
	logic [CNT_W-1:0]   ci_q;
	logic               zero_q [2];
	logic signed [24:0] num [2];

	assign num[0] = 25'(item_q.accel_y) <<< 8;
	assign num[1] = -(25'(item_q.accel_x) <<< 8);

	always_ff @(posedge clk) begin
		if (cmd.cordic_init) begin
			for (int k = 0; k < 2; k++) begin
				cx_q[k] <= 32'($signed({1'b0, root_q[k]}));
				cy_q[k] <= 32'(num[k]);
				cz_q[k] <= '0;
				zero_q[k] <= (root_q[k] == '0) && (num[k] == '0);
			end
			ci_q <= '0;
		end else if (cmd.cordic_step) begin
			for (int k = 0; k < 2; k++) begin
				logic signed [31:0] xs, ys;
				xs = cx_q[k] >>> ci_q;
				ys = cy_q[k] >>> ci_q;
				if (!cy_q[k][31]) begin
					cx_q[k] <= cx_q[k] + ys;
					cy_q[k] <= cy_q[k] - xs;
					cz_q[k] <= cz_q[k] + atan_deg(5'(ci_q));
				end else begin
					cx_q[k] <= cx_q[k] - ys;
					cy_q[k] <= cy_q[k] + xs;
					cz_q[k] <= cz_q[k] - atan_deg(5'(ci_q));
				end
			end
			ci_q <= ci_q + CNT_W'(1);
		end
	end

	assign stat = '{
		sqrt_done:   (sq_cnt_q == 5'd24) && cmd.sqrt_step,
		cordic_done: cmd.cordic_step && (ci_q == CNT_W'(CORDIC_STEPS - 1))
	};

	// --- gyro integration, one axis at a time
	// fs / 500 is 2^sel / 2, so the increment is rate * ms * 2^sel halved,
	// rounded half away from zero
	logic signed [31:0] gang_q [3];
	logic signed [27:0] rf_s1;
	logic signed [44:0] n_s2;
	logic signed [15:0] rate_sel;

	always_comb begin
		case (cmd.axis)
			2'd0: rate_sel = item_q.rate_x;
			2'd1: rate_sel = item_q.rate_y;
			default: rate_sel = item_q.rate_z;
		endcase
	end

	logic [44:0] mag;
	logic [44:0] q500;
	logic signed [46:0] inc;
	logic signed [47:0] acc_sum;
	assign mag  = n_s2[44] ? 45'(-n_s2) + 45'd1 : 45'(n_s2) + 45'd1;
	assign q500 = {1'b0, mag[44:1]};
	assign inc = n_s2[44] ? -$signed({2'b00, q500}) : $signed({2'b00, q500});
	assign acc_sum = 48'(gang_q[cmd.axis]) + 48'(inc) - 48'(drift_q[cmd.axis]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gang_q[0] <= '0; gang_q[1] <= '0; gang_q[2] <= '0;
		end else if (cmd.gyro_div) begin
			if (acc_sum > 48'sd2147483647) gang_q[cmd.axis] <= 32'h7fffffff;
			else if (acc_sum < -48'sd2147483648) gang_q[cmd.axis] <= 32'h80000000;
			else gang_q[cmd.axis] <= acc_sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.gyro_mul) rf_s1 <= 28'(rate_sel) <<< gyro_sel_q;
		if (cmd.gyro_mul2) n_s2 <= rf_s1 * $signed({1'b0, item_q.elapsed_ms});
	end

	// --- blend
	logic signed [32:0] tilt;
	logic signed [50:0] bm_g_s1, bm_a_s1;
	logic signed [51:0] bsum;
	logic signed [35:0] bsh;
	logic signed [31:0] res_q [2];

	assign tilt = (zero_q[cmd.axis[0]] ? 33'sd0 : 33'(cz_q[cmd.axis[0]]))
		- 33'(tilt_ofs_q[cmd.axis[0]]);
	assign bsum = 52'(bm_g_s1) + 52'(bm_a_s1) + 52'sd32768;
	assign bsh  = 36'(bsum >>> 16);

	always_ff @(posedge clk) begin
		if (cmd.blend_mul) begin
			bm_g_s1 <= $signed({1'b0, blend_w_q}) * gang_q[cmd.axis[0]];
			bm_a_s1 <= $signed(18'd65536 - {2'b0, blend_w_q}) * tilt;
		end
		if (cmd.blend_fin) begin
			if (bsh > 36'sd2147483647) res_q[cmd.axis[0]] <= 32'h7fffffff;
			else if (bsh < -36'sd2147483648) res_q[cmd.axis[0]] <= 32'h80000000;
			else res_q[cmd.axis[0]] <= bsh[31:0];
		end
	end

	assign out_item = '{
		roll_deg:  res_q[0],
		pitch_deg: res_q[1],
		yaw_deg:   gang_q[2]
	};
endmodule

FILE: hw/rtl/tilt_gyro_complementary_blend_unit.sv
//------------------------------------------------------------------------------
// tilt_gyro_complementary_blend_unit
// Complementary tilt filter: accel tilt via root + CORDIC, gyro integration.
//------------------------------------------------------------------------------
// One input beat (raw accel xyz, gyro xyz, elapsed ms) yields one output beat
// (roll, pitch, yaw in Q16.16 degrees). Channels are valid/ready; a beat moves
// when both are high. The user must write registers through cfg_we/cfg_idx/
// cfg_data only while the unit is idle; the block itself does not enforce it.
// Sequence: after the accepting edge, the bit-serial roots (2 bits per cycle),
// a CORDIC init and CORDIC_STEPS shared shift-add steps, the three gyro axes
// in turn (scale, multiply by ms, round and accumulate) and the roll and pitch
// blend (multiply, round and saturate); the result is then held until taken.
// One beat is in flight at a time, and after the result is taken the unit
// returns to idle before it accepts the next beat.
// Reset clears the gyro angles and loads register defaults. While the receiver
// stalls, the result holds and no new beat is accepted.
//------------------------------------------------------------------------------
module tilt_gyro_complementary_blend_unit #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tgcb_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [tgcb_pkg::CFG_DATA_W-1:0]   cfg_data,
	tgcb_stream_if.sink                       in_ch,
	tgcb_stream_if.source                     out_ch
);
	import tgcb_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tgcb_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	tgcb_dpath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dpath (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_item(in_ch.data), .cmd(cmd), .stat(stat), .out_item(out_ch.data)
	);
endmodule

FILE: hw/rtl/tgcb_checker.sv
//------------------------------------------------------------------------------
// tgcb_checker
// Port-level properties of the blend unit.
//------------------------------------------------------------------------------
module tgcb_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input open while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready && !out_valid) else $error("no busy phase");
	a_ret: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> in_ready) else $error("not idle after beat");
endmodule

bind tilt_gyro_complementary_blend_unit tgcb_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready)
);
